### src/swsr_pkg.sv
package swsr_pkg;

    localparam int unsigned TICK_W  = 22;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BIT_IDX_W = 3;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = 3'd7;
    localparam logic [COUNT_W-1:0]   MAX_FRAME_BYTES = 4'd8;

    localparam logic [21:0] POWER_UP_RST     = 22'd2000000;
    localparam logic [15:0] START_LOW_RST    = 16'd20000;
    localparam logic [7:0]  RELEASE_WAIT_RST = 8'd40;
    localparam logic [7:0]  SAMPLE_DELAY_RST = 8'd40;
    localparam logic [3:0]  BYTE_COUNT_RST   = 4'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_WAIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_COUNT   = 3'd4;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_POWER     = 4'd1,
        PH_START     = 4'd2,
        PH_RELEASE   = 4'd3,
        PH_RESP_LOW  = 4'd4,
        PH_RESP_HIGH = 4'd5,
        PH_BIT_LOW   = 4'd6,
        PH_BIT_DELAY = 4'd7,
        PH_BIT_HIGH  = 4'd8
    } t_phase;

    typedef struct packed {
        logic [21:0] power_up_ticks;
        logic [15:0] start_low_ticks;
        logic [7:0]  release_wait_ticks;
        logic [7:0]  sample_delay_ticks;
        logic [3:0]  byte_count;
    } t_cfg;

    typedef struct packed {
        logic              drive_low;
        logic              byte_valid;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
        logic              busy_res;
    } t_res;

endpackage

### src/swsr_core.sv
module swsr_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic          i_pin_level,
    input  logic          i_start_request,
    input  swsr_pkg::t_cfg i_cfg,
    output swsr_pkg::t_res o_res
);

    swsr_pkg::t_phase r_phase, n_phase;
    logic [swsr_pkg::TICK_W-1:0]    r_tick, n_tick;
    logic [swsr_pkg::BYTE_W-1:0]    r_shift, n_shift;
    logic [swsr_pkg::BIT_IDX_W-1:0] r_bit, n_bit;
    logic [swsr_pkg::COUNT_W-1:0]   r_bytes, n_bytes;

    logic [swsr_pkg::TICK_W-1:0]  wait_limit;
    logic                         wait_over;
    logic [swsr_pkg::TICK_W-1:0]  tick_inc;
    logic [swsr_pkg::COUNT_W-1:0] frame_len;
    logic [swsr_pkg::COUNT_W-1:0] bytes_inc;
    logic                         bit_end;
    logic                         byte_done;
    logic                         frame_done;

    // frame length with out-of-range counts clamped
    always_comb begin
        if (i_cfg.byte_count == '0) begin
            frame_len = swsr_pkg::COUNT_W'(1);
        end else if (i_cfg.byte_count > swsr_pkg::MAX_FRAME_BYTES) begin
            frame_len = swsr_pkg::MAX_FRAME_BYTES;
        end else begin
            frame_len = i_cfg.byte_count;
        end
    end

    always_comb begin
        unique case (r_phase)
            swsr_pkg::PH_POWER:     wait_limit = i_cfg.power_up_ticks;
            swsr_pkg::PH_START:     wait_limit = {6'd0, i_cfg.start_low_ticks};
            swsr_pkg::PH_RELEASE:   wait_limit = {14'd0, i_cfg.release_wait_ticks};
            swsr_pkg::PH_BIT_DELAY: wait_limit = {14'd0, i_cfg.sample_delay_ticks};
            default:                wait_limit = '0;
        endcase
    end

    assign wait_over = (r_tick >= wait_limit);
    assign tick_inc  = r_tick + swsr_pkg::TICK_W'(1);
    assign bytes_inc = r_bytes + swsr_pkg::COUNT_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_shift    = r_shift;
        n_bit      = r_bit;
        n_bytes    = r_bytes;
        bit_end    = 1'b0;
        byte_done  = 1'b0;
        frame_done = 1'b0;

        unique case (r_phase)
            swsr_pkg::PH_IDLE: begin
                if (i_start_request) begin
                    n_shift = '0;
                    n_bit   = '0;
                    n_bytes = '0;
                    n_phase = swsr_pkg::PH_POWER;
                    n_tick  = '0;
                end
            end
            swsr_pkg::PH_POWER: begin
                if (wait_over) begin
                    n_phase = swsr_pkg::PH_START;
                    n_tick  = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            swsr_pkg::PH_START: begin
                if (wait_over) begin
                    n_phase = swsr_pkg::PH_RELEASE;
                    n_tick  = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            swsr_pkg::PH_RELEASE: begin
                if (wait_over) begin
                    // no response from the sensor: go straight to the bits
                    n_phase = i_pin_level ? swsr_pkg::PH_BIT_LOW : swsr_pkg::PH_RESP_LOW;
                    n_tick  = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            swsr_pkg::PH_RESP_LOW: begin
                if (i_pin_level) begin
                    n_phase = swsr_pkg::PH_RESP_HIGH;
                    n_tick  = '0;
                end
            end
            swsr_pkg::PH_RESP_HIGH: begin
                if (!i_pin_level) begin
                    n_phase = swsr_pkg::PH_BIT_LOW;
                    n_tick  = '0;
                end
            end
            swsr_pkg::PH_BIT_LOW: begin
                if (i_pin_level) begin
                    n_phase = swsr_pkg::PH_BIT_DELAY;
                    n_tick  = '0;
                end
            end
            swsr_pkg::PH_BIT_DELAY: begin
                if (wait_over) begin
                    n_shift = {r_shift[swsr_pkg::BYTE_W-2:0], i_pin_level};
                    if (i_pin_level) begin
                        n_phase = swsr_pkg::PH_BIT_HIGH;
                        n_tick  = '0;
                    end else begin
                        bit_end = 1'b1;
                    end
                end else begin
                    n_tick = tick_inc;
                end
            end
            swsr_pkg::PH_BIT_HIGH: begin
                if (!i_pin_level) begin
                    bit_end = 1'b1;
                end
            end
            default: begin
                n_phase = swsr_pkg::PH_IDLE;
                n_tick  = '0;
            end
        endcase

        // end of a bit: advance bit and byte counts
        if (bit_end) begin
            n_tick = '0;
            if (r_bit == swsr_pkg::LAST_BIT_IDX) begin
                n_bit     = '0;
                n_bytes   = bytes_inc;
                byte_done = 1'b1;
                if (bytes_inc >= frame_len) begin
                    frame_done = 1'b1;
                    n_phase    = swsr_pkg::PH_IDLE;
                end else begin
                    n_phase = swsr_pkg::PH_BIT_LOW;
                end
            end else begin
                n_bit   = r_bit + swsr_pkg::BIT_IDX_W'(1);
                n_phase = swsr_pkg::PH_BIT_LOW;
            end
        end

        o_res.drive_low  = (n_phase == swsr_pkg::PH_START);
        o_res.byte_valid = byte_done;
        o_res.data_byte  = byte_done ? n_shift : '0;
        o_res.last_byte  = frame_done;
        o_res.busy_res   = (n_phase != swsr_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= swsr_pkg::PH_IDLE;
            r_tick  <= '0;
            r_shift <= '0;
            r_bit   <= '0;
            r_bytes <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_shift <= n_shift;
            r_bit   <= n_bit;
            r_bytes <= n_bytes;
        end
    end

endmodule

### src/single_wire_sensor_reader.sv
// single-wire humidity/temperature sensor reader, master side
// input channel: one beat per 1 us tick carrying the sampled line level and a
//   start request; a beat is taken when i_valid is high and o_stall is low
// output channel: exactly one result beat per input beat, in order, taken
//   when o_valid is high and i_stall is low; o_drive_low and o_busy_res give
//   the state after that tick, o_byte_valid marks a completed byte
// config channel: i_cfg_index selects power-up, start-low, release-wait,
//   sample-delay or byte-count (0..4); written when i_cfg_valid and
//   o_cfg_ready are high; o_cfg_ready is always high, write only while no
//   beat is in flight
// output register: a result appears in the cycle after its input beat is taken
// throughput: one beat per cycle while the receiver does not stall; the phase
//   machine and tick counter advance once per taken beat, and the result
//   register is refilled in the same cycle it is emptied
// receiver stall: the result register holds; o_stall rises only while a
//   result is waiting and i_stall is high
// reset (i_rst_n low, synchronous): idle phase, counters cleared, registers
//   back to their defaults, no result pending
module single_wire_sensor_reader (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_pin_level,
    input  logic        i_start_request,

    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_drive_low,
    output logic        o_byte_valid,
    output logic [7:0]  o_data_byte,
    output logic        o_last_byte,
    output logic        o_busy_res,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [21:0] i_cfg_data
);

    swsr_pkg::t_cfg r_cfg;
    swsr_pkg::t_res core_res;
    swsr_pkg::t_res r_res;
    logic           r_out_valid, n_out_valid;
    logic           in_take;
    logic           out_take;

    // input beat taken; the result slot is free or being emptied this cycle
    assign o_stall  = r_out_valid & i_stall;
    assign in_take  = i_valid & ~o_stall;
    assign out_take = r_out_valid & ~i_stall;

    assign o_cfg_ready = 1'b1;

    // configuration registers, new values take effect at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_up_ticks     <= swsr_pkg::POWER_UP_RST;
            r_cfg.start_low_ticks    <= swsr_pkg::START_LOW_RST;
            r_cfg.release_wait_ticks <= swsr_pkg::RELEASE_WAIT_RST;
            r_cfg.sample_delay_ticks <= swsr_pkg::SAMPLE_DELAY_RST;
            r_cfg.byte_count         <= swsr_pkg::BYTE_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                swsr_pkg::CFG_POWER_UP:     r_cfg.power_up_ticks     <= i_cfg_data;
                swsr_pkg::CFG_START_LOW:    r_cfg.start_low_ticks    <= i_cfg_data[15:0];
                swsr_pkg::CFG_RELEASE_WAIT: r_cfg.release_wait_ticks <= i_cfg_data[7:0];
                swsr_pkg::CFG_SAMPLE_DELAY: r_cfg.sample_delay_ticks <= i_cfg_data[7:0];
                swsr_pkg::CFG_BYTE_COUNT:   r_cfg.byte_count         <= i_cfg_data[3:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    // phase machine, tick counter and byte assembly
    swsr_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (in_take),
        .i_pin_level     (i_pin_level),
        .i_start_request (i_start_request),
        .i_cfg           (r_cfg),
        .o_res           (core_res)
    );

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (in_take) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_res <= core_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_drive_low  = r_res.drive_low;
    assign o_byte_valid = r_res.byte_valid;
    assign o_data_byte  = r_res.data_byte;
    assign o_last_byte  = r_res.last_byte;
    assign o_busy_res   = r_res.busy_res;

endmodule

### dv/single_wire_sensor_reader_checker.sv
module single_wire_sensor_reader_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_pin_level,
    input  logic        i_start_request,

    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_drive_low,
    input  logic        i_byte_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_busy_res,

    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [21:0] i_cfg_data,

    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // own copy of the line master
    swsr_pkg::t_cfg                 cfg;
    swsr_pkg::t_phase               line_phase;
    logic [swsr_pkg::TICK_W-1:0]    wait_count;
    logic [swsr_pkg::BYTE_W-1:0]    rx_shift;
    logic [swsr_pkg::BIT_IDX_W-1:0] rx_bit;
    logic [swsr_pkg::COUNT_W-1:0]   rx_bytes;

    swsr_pkg::t_res due_results[$];
    swsr_pkg::t_res seen;
    swsr_pkg::t_res want;

    function automatic logic [swsr_pkg::COUNT_W-1:0] frame_bytes();
        if (cfg.byte_count == '0) return 4'd1;
        if (cfg.byte_count > swsr_pkg::MAX_FRAME_BYTES) return swsr_pkg::MAX_FRAME_BYTES;
        return cfg.byte_count;
    endfunction

    function automatic bit wait_over(input logic [swsr_pkg::TICK_W-1:0] limit);
        if (wait_count >= limit) return 1'b1;
        wait_count = wait_count + swsr_pkg::TICK_W'(1);
        return 1'b0;
    endfunction

    function automatic void go(input swsr_pkg::t_phase p);
        line_phase = p;
        wait_count = '0;
    endfunction

    // closes one bit, true when a byte is complete
    function automatic bit end_bit(output bit last);
        last = 1'b0;
        if (rx_bit >= swsr_pkg::LAST_BIT_IDX) begin
            rx_bit = '0;
            rx_bytes = rx_bytes + swsr_pkg::COUNT_W'(1);
            if (rx_bytes >= frame_bytes()) begin
                last = 1'b1;
                go(swsr_pkg::PH_IDLE);
            end else begin
                go(swsr_pkg::PH_BIT_LOW);
            end
            return 1'b1;
        end
        rx_bit = rx_bit + swsr_pkg::BIT_IDX_W'(1);
        go(swsr_pkg::PH_BIT_LOW);
        return 1'b0;
    endfunction

    function automatic swsr_pkg::t_res step_line_master(input logic pin, input logic req);
        swsr_pkg::t_res r;
        bit             done_byte;
        bit             last;
        done_byte = 1'b0;
        last = 1'b0;
        case (line_phase)
            swsr_pkg::PH_IDLE: begin
                if (req) begin
                    rx_shift = '0;
                    rx_bit = '0;
                    rx_bytes = '0;
                    go(swsr_pkg::PH_POWER);
                end
            end
            swsr_pkg::PH_POWER: begin
                if (wait_over(cfg.power_up_ticks)) go(swsr_pkg::PH_START);
            end
            swsr_pkg::PH_START: begin
                if (wait_over(swsr_pkg::TICK_W'(cfg.start_low_ticks)))
                    go(swsr_pkg::PH_RELEASE);
            end
            swsr_pkg::PH_RELEASE: begin
                if (wait_over(swsr_pkg::TICK_W'(cfg.release_wait_ticks))) begin
                    if (pin) go(swsr_pkg::PH_BIT_LOW);
                    else go(swsr_pkg::PH_RESP_LOW);
                end
            end
            swsr_pkg::PH_RESP_LOW: begin
                if (pin) go(swsr_pkg::PH_RESP_HIGH);
            end
            swsr_pkg::PH_RESP_HIGH: begin
                if (!pin) go(swsr_pkg::PH_BIT_LOW);
            end
            swsr_pkg::PH_BIT_LOW: begin
                if (pin) go(swsr_pkg::PH_BIT_DELAY);
            end
            swsr_pkg::PH_BIT_DELAY: begin
                if (wait_over(swsr_pkg::TICK_W'(cfg.sample_delay_ticks))) begin
                    rx_shift = {rx_shift[swsr_pkg::BYTE_W-2:0], pin};
                    if (pin) go(swsr_pkg::PH_BIT_HIGH);
                    else done_byte = end_bit(last);
                end
            end
            swsr_pkg::PH_BIT_HIGH: begin
                if (!pin) done_byte = end_bit(last);
            end
            default: begin
                go(swsr_pkg::PH_IDLE);
            end
        endcase
        r.drive_low  = (line_phase == swsr_pkg::PH_START);
        r.byte_valid = done_byte;
        r.data_byte  = done_byte ? rx_shift : '0;
        r.last_byte  = done_byte && last;
        r.busy_res   = (line_phase != swsr_pkg::PH_IDLE);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.power_up_ticks     = swsr_pkg::POWER_UP_RST;
            cfg.start_low_ticks    = swsr_pkg::START_LOW_RST;
            cfg.release_wait_ticks = swsr_pkg::RELEASE_WAIT_RST;
            cfg.sample_delay_ticks = swsr_pkg::SAMPLE_DELAY_RST;
            cfg.byte_count         = swsr_pkg::BYTE_COUNT_RST;
            line_phase = swsr_pkg::PH_IDLE;
            wait_count = '0;
            rx_shift   = '0;
            rx_bit     = '0;
            rx_bytes   = '0;
            o_fail_count = 0;
            due_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen = {i_drive_low, i_byte_valid, i_data_byte, i_last_byte, i_busy_res};
                if (due_results.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10)
                        $display({"%0t: result beat with nothing due:",
                                  " drive=%b vld=%b data=%h last=%b busy=%b"},
                                 $time, seen.drive_low, seen.byte_valid, seen.data_byte,
                                 seen.last_byte, seen.busy_res);
                end else begin
                    want = due_results.pop_front();
                    if (seen !== want) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10)
                            $display({"%0t: mismatch drive/vld/data/last/busy",
                                      " expected %b/%b/%h/%b/%b got %b/%b/%h/%b/%b"},
                                     $time, want.drive_low, want.byte_valid, want.data_byte,
                                     want.last_byte, want.busy_res, seen.drive_low,
                                     seen.byte_valid, seen.data_byte, seen.last_byte,
                                     seen.busy_res);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    swsr_pkg::CFG_POWER_UP:     cfg.power_up_ticks     = i_cfg_data;
                    swsr_pkg::CFG_START_LOW:    cfg.start_low_ticks    = i_cfg_data[15:0];
                    swsr_pkg::CFG_RELEASE_WAIT: cfg.release_wait_ticks = i_cfg_data[7:0];
                    swsr_pkg::CFG_SAMPLE_DELAY: cfg.sample_delay_ticks = i_cfg_data[7:0];
                    swsr_pkg::CFG_BYTE_COUNT:   cfg.byte_count         = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                due_results.push_back(step_line_master(i_pin_level, i_start_request));
        end
        o_pending = due_results.size();
    end

endmodule

### dv/single_wire_sensor_reader_tb.sv
module single_wire_sensor_reader_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // generous cutoff, the slowest correct run stays far below this
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_BEATS = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_pin_level = 1'b1;
    logic        i_start_request = 1'b0;

    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_drive_low;
    logic        o_byte_valid;
    logic [7:0]  o_data_byte;
    logic        o_last_byte;
    logic        o_busy_res;

    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [21:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int beats_sent = 0;
    int hold_cnt = 0;
    bit idle_on = 1'b1;

    // stimulus-side copy of the register settings, used to shape the sensor replies
    logic [21:0] set_power   = swsr_pkg::POWER_UP_RST;
    logic [15:0] set_start   = swsr_pkg::START_LOW_RST;
    logic [7:0]  set_release = swsr_pkg::RELEASE_WAIT_RST;
    logic [7:0]  set_sample  = swsr_pkg::SAMPLE_DELAY_RST;
    logic [3:0]  set_bytes   = swsr_pkg::BYTE_COUNT_RST;

    single_wire_sensor_reader uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pin_level     (i_pin_level),
        .i_start_request (i_start_request),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_drive_low     (o_drive_low),
        .o_byte_valid    (o_byte_valid),
        .o_data_byte     (o_data_byte),
        .o_last_byte     (o_last_byte),
        .o_busy_res      (o_busy_res),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    single_wire_sensor_reader_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_pin_level     (i_pin_level),
        .i_start_request (i_start_request),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_drive_low     (o_drive_low),
        .i_byte_valid    (o_byte_valid),
        .i_data_byte     (o_data_byte),
        .i_last_byte     (o_last_byte),
        .i_busy_res      (o_busy_res),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #4 i_clk = ~i_clk;

    // receiver stall: random bursts between runs of free flow, none while idle_on is low
    always @(negedge i_clk) begin
        if (!idle_on) begin
            i_stall <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!i_stall && $urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            hold_cnt <= $urandom_range(0, 9);
        end else begin
            i_stall <= 1'b0;
            hold_cnt <= $urandom_range(0, 12);
        end
    end

    // run cutoff
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count = cycle_count + 1;
        end
        $display("single_wire_sensor_reader regression: fail");
        $finish;
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // one tick beat; an optional sender gap with i_valid low comes first while idle_on is set
    task automatic send_tick(input logic pin, input logic req);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pin_level <= pin;
        i_start_request <= req;
        do @(posedge i_clk); while (o_stall);
        beats_sent = beats_sent + 1;
    endtask

    // stop beats and wait until every due result has come back
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic program_reg(input logic [2:0] index, input logic [21:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (index)
            swsr_pkg::CFG_POWER_UP:     set_power   = data;
            swsr_pkg::CFG_START_LOW:    set_start   = data[15:0];
            swsr_pkg::CFG_RELEASE_WAIT: set_release = data[7:0];
            swsr_pkg::CFG_SAMPLE_DELAY: set_sample  = data[7:0];
            swsr_pkg::CFG_BYTE_COUNT:   set_bytes   = data[3:0];
            default: ;
        endcase
    endtask

    // drain, then write all five registers; unused upper data bits carry junk
    task automatic program_all(input logic [21:0] p, input logic [15:0] s,
                               input logic [7:0] r, input logic [7:0] d,
                               input logic [3:0] b);
        settle();
        program_reg(swsr_pkg::CFG_POWER_UP, p);
        program_reg(swsr_pkg::CFG_START_LOW, {6'($urandom), s});
        program_reg(swsr_pkg::CFG_RELEASE_WAIT, {14'($urandom), r});
        program_reg(swsr_pkg::CFG_SAMPLE_DELAY, {14'($urandom), d});
        program_reg(swsr_pkg::CFG_BYTE_COUNT, {18'($urandom), b});
    endtask

    // sensor side after the release: optional response, then nbits data bits
    // fill: 0 all zeros, 1 all ones, otherwise random bits
    task automatic sensor_reply(input bit respond, input int fill, input int nbits);
        int   d;
        logic bitv;
        d = int'(set_sample);
        if (respond) begin
            // the first low tick is the one the response check sees
            repeat ($urandom_range(1, 4)) send_tick(1'b0, coin());
            repeat ($urandom_range(1, 4)) send_tick(1'b1, coin());
        end else begin
            send_tick(1'b1, coin());
        end
        for (int i = 0; i < nbits; i++) begin
            repeat ($urandom_range(1, 4)) send_tick(1'b0, coin());
            bitv = (fill == 0) ? 1'b0 : (fill == 1) ? 1'b1 : coin();
            // a one outlasts the sample point, a zero falls at or before it
            if (bitv) repeat ($urandom_range(d + 2, d + 4)) send_tick(1'b1, coin());
            else repeat ($urandom_range(1, d + 1)) send_tick(1'b1, coin());
        end
        // closing low edge, then the idle-high line
        repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0);
        repeat ($urandom_range(2, 6)) send_tick(1'b1, 1'b0);
    endtask

    // full transaction from the request; keep_bits >= 0 cuts the frame short
    task automatic run_frame(input bit respond, input int fill, input int keep_bits);
        int nbits;
        if (set_bytes == 4'd0) nbits = 8;
        else if (set_bytes > swsr_pkg::MAX_FRAME_BYTES)
            nbits = 8 * int'(swsr_pkg::MAX_FRAME_BYTES);
        else nbits = 8 * int'(set_bytes);
        if (keep_bits >= 0 && keep_bits < nbits) nbits = keep_bits;
        send_tick(1'b1, 1'b1);
        // power-up, start pulse and release wait, with requests while busy
        repeat (int'(set_power) + int'(set_start) + int'(set_release) + 2)
            send_tick(1'b1, coin());
        sensor_reply(respond, fill, nbits);
    endtask

    initial begin
        int random_goal;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // idle ticks at reset settings, line both ways, no request
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);

        // shortest timing, byte count zero acts as one byte
        program_all(22'd0, 16'd1, 8'd0, 8'd0, 4'd0);
        run_frame(1'b1, 1, -1);
        run_frame(1'b0, 0, -1);

        // longest release wait, byte count above the frame maximum
        program_all(22'd3, 16'd2, 8'd255, 8'd0, 4'd15);
        run_frame(1'b1, 2, -1);

        // longest sample delay on one bit, rest of the byte at zero delay
        program_all(22'd0, 16'd1, 8'd0, 8'd255, 4'd1);
        run_frame(1'b1, 2, 1);
        settle();
        program_reg(swsr_pkg::CFG_SAMPLE_DELAY, 22'd0);
        for (int i = 0; i < 24; i++) send_tick(i[0], 1'b0);

        // longest start pulse, cut short by a write while the pulse runs
        program_all(22'd0, 16'hFFFF, 8'd1, 8'd2, 4'd2);
        send_tick(1'b1, 1'b1);
        repeat (41) send_tick(1'b1, coin());
        settle();
        program_reg(swsr_pkg::CFG_START_LOW, 22'd3);
        repeat (2) send_tick(1'b1, coin());
        sensor_reply(1'b1, 2, 16);

        // writes to unused indexes are dropped
        settle();
        for (int idx = int'(swsr_pkg::CFG_BYTE_COUNT) + 1; idx < 8; idx++)
            program_reg(3'(idx), 22'($urandom));

        // longest power-up, cut short by a write while the wait runs
        program_all(22'h3FFFFF, 16'd3, 8'd2, 8'd1, 4'd2);
        send_tick(1'b1, 1'b1);
        repeat (30) send_tick(1'b1, coin());
        settle();
        program_reg(swsr_pkg::CFG_POWER_UP, 22'd5);
        repeat (int'(set_start) + int'(set_release) + 2) send_tick(1'b1, coin());
        sensor_reply(1'b1, 2, 16);

        // broken frame, sample delay changed mid-bit, then recovery
        program_all(22'd1, 16'd1, 8'd1, 8'd1, 4'd1);
        run_frame(1'b1, 2, 5);
        settle();
        program_reg(swsr_pkg::CFG_SAMPLE_DELAY, 22'd3);
        repeat (30) send_tick(coin(), coin());
        run_frame(1'b1, 2, -1);

        // ---- random part: mostly clean frames, some noise and cut frames ----
        random_goal = beats_sent + RANDOM_BEATS;
        while (beats_sent < random_goal) begin
            idle_on = ($urandom_range(0, 3) != 0);
            program_all(22'($urandom_range(0, 20)), 16'($urandom_range(1, 20)),
                        8'($urandom_range(0, 10)), 8'($urandom_range(0, 6)),
                        ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(1, 3)));
            repeat ($urandom_range(2, 4)) begin
                case ($urandom_range(0, 9))
                    0: repeat ($urandom_range(10, 40)) send_tick(coin(), coin());
                    1: run_frame(coin(), 2, $urandom_range(0, 20));
                    default: run_frame($urandom_range(0, 7) != 0, 2, -1);
                endcase
            end
        end

        // ---- last part: no idling on either side ----
        idle_on = 1'b0;
        program_all(22'($urandom_range(0, 8)), 16'($urandom_range(1, 8)),
                    8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)), 4'd1);
        run_frame(1'b1, 2, -1);
        run_frame(1'b0, 2, -1);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("single_wire_sensor_reader regression: pass");
        end else begin
            $display("single_wire_sensor_reader regression: fail");
        end
        $finish;
    end

endmodule
